FILE: hw/rtl/ssw_pkg.sv
// Servo sync-write framer package: shared types, packet constants and slot numbers.
// No dependencies.
`default_nettype none

package ssw_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_FIRST_ID  = 2'd0;
   localparam logic [1:0] REG_FIRST_POS = 2'd1;
   localparam logic [1:0] REG_SECOND_ID = 2'd2;

   // packet constants
   localparam logic [7:0] HDR_BYTE     = 8'hFF;
   localparam logic [7:0] BCAST_ID     = 8'hFE;
   localparam logic [7:0] PKT_LENGTH   = 8'h0E;
   localparam logic [7:0] INST_SYNC_WR = 8'h83;
   localparam logic [7:0] START_ADDR   = 8'h1E;
   localparam logic [7:0] DATA_LEN     = 8'h04;

   // byte slots within the packet
   localparam logic [4:0] SLOT_HDR0  = 5'd0;
   localparam logic [4:0] SLOT_HDR1  = 5'd1;
   localparam logic [4:0] SLOT_BCAST = 5'd2;
   localparam logic [4:0] SLOT_LEN   = 5'd3;
   localparam logic [4:0] SLOT_INST  = 5'd4;
   localparam logic [4:0] SLOT_ADDR  = 5'd5;
   localparam logic [4:0] SLOT_DLEN  = 5'd6;
   localparam logic [4:0] SLOT_ID1   = 5'd7;
   localparam logic [4:0] SLOT_POS1L = 5'd8;
   localparam logic [4:0] SLOT_POS1H = 5'd9;
   localparam logic [4:0] SLOT_SPD1L = 5'd10;
   localparam logic [4:0] SLOT_SPD1H = 5'd11;
   localparam logic [4:0] SLOT_ID2   = 5'd12;
   localparam logic [4:0] SLOT_POS2L = 5'd13;
   localparam logic [4:0] SLOT_POS2H = 5'd14;
   localparam logic [4:0] SLOT_SPD2L = 5'd15;
   localparam logic [4:0] SLOT_SPD2H = 5'd16;
   localparam logic [4:0] SLOT_CHK   = 5'd17;

   // reciprocal constants: 256*a/75 and 512*s/57, exact over the input ranges
   localparam logic [17:0] POS_RECIP = 18'd223697;  // ceil(2^24/75)
   localparam int          POS_SHIFT = 24;
   localparam logic [16:0] SPD_RECIP = 17'd73585;   // ceil(2^22/57)
   localparam int          SPD_SHIFT = 22;
   localparam logic [9:0]  CODE_MAX  = 10'd1023;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [9:0] pos_code;
      logic [9:0] spd_code;
   } cmd_type;

   typedef struct packed {
      logic [7:0] first_id;
      logic [9:0] first_pos;
      logic [7:0] second_id;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ssw_front.sv
// Front end: scales angle and speed to 10-bit codes for the command queue.
// Depends on ssw_pkg.
`default_nettype none

module ssw_front (
   input  wire logic [8:0]     angle_deg,
   input  wire logic [6:0]     speed_rpm,
   output ssw_pkg::cmd_type    cmd
);

   logic [16:0] pos_num;
   logic [15:0] spd_num;
   logic [34:0] pos_prod;
   logic [32:0] spd_prod;
   logic [10:0] pos_q;
   logic [10:0] spd_q;

   assign pos_num  = {angle_deg, 8'b0};
   assign spd_num  = {speed_rpm, 9'b0};
   assign pos_prod = 35'(pos_num) * 35'(ssw_pkg::POS_RECIP);
   assign spd_prod = 33'(spd_num) * 33'(ssw_pkg::SPD_RECIP);
   assign pos_q    = 11'(pos_prod >> ssw_pkg::POS_SHIFT);
   assign spd_q    = 11'(spd_prod >> ssw_pkg::SPD_SHIFT);

   always_comb begin
      cmd.pos_code = (pos_q > 11'(ssw_pkg::CODE_MAX)) ? ssw_pkg::CODE_MAX : pos_q[9:0];
      cmd.spd_code = (spd_q > 11'(ssw_pkg::CODE_MAX)) ? ssw_pkg::CODE_MAX : spd_q[9:0];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ssw_queue.sv
// Two-entry command queue between front end and packet sequencer.
// Depends on ssw_pkg.
`default_nettype none

module ssw_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ssw_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output ssw_pkg::cmd_type      head_cmd,
   output logic                  head_valid
);

   ssw_pkg::cmd_type entry_ff [ssw_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'(ssw_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ssw_back.sv
// Packet sequencer: walks the 18 byte slots for the head command, keeps a running
// checksum and drives the registered result word. Depends on ssw_pkg.
`default_nettype none

module ssw_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ssw_pkg::cfg_type cfg,
   input  wire logic             head_valid,
   input  wire ssw_pkg::cmd_type head_cmd,
   output logic                  head_pop,
   output logic [7:0]            tx_byte,
   output logic                  last_byte,
   output logic                  empty,
   input  wire logic             pop
);

   logic [4:0] slot_ff, slot_in;
   logic [7:0] sum_ff, sum_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       advance;
   logic [7:0] cur_byte;
   logic [9:0] fpos;

   assign empty     = !out_valid_ff;
   assign tx_byte   = out_byte_ff;
   assign last_byte = out_last_ff;
   assign advance   = head_valid && (!out_valid_ff || pop);
   assign head_pop  = advance && (slot_ff == ssw_pkg::SLOT_CHK);
   assign fpos      = cfg.first_pos;

   always_comb begin
      case (slot_ff)
         ssw_pkg::SLOT_HDR0:  cur_byte = ssw_pkg::HDR_BYTE;
         ssw_pkg::SLOT_HDR1:  cur_byte = ssw_pkg::HDR_BYTE;
         ssw_pkg::SLOT_BCAST: cur_byte = ssw_pkg::BCAST_ID;
         ssw_pkg::SLOT_LEN:   cur_byte = ssw_pkg::PKT_LENGTH;
         ssw_pkg::SLOT_INST:  cur_byte = ssw_pkg::INST_SYNC_WR;
         ssw_pkg::SLOT_ADDR:  cur_byte = ssw_pkg::START_ADDR;
         ssw_pkg::SLOT_DLEN:  cur_byte = ssw_pkg::DATA_LEN;
         ssw_pkg::SLOT_ID1:   cur_byte = cfg.first_id;
         ssw_pkg::SLOT_POS1L: cur_byte = fpos[7:0];
         ssw_pkg::SLOT_POS1H: cur_byte = {6'd0, fpos[9:8]};
         ssw_pkg::SLOT_SPD1L: cur_byte = head_cmd.spd_code[7:0];
         ssw_pkg::SLOT_SPD1H: cur_byte = {6'd0, head_cmd.spd_code[9:8]};
         ssw_pkg::SLOT_ID2:   cur_byte = cfg.second_id;
         ssw_pkg::SLOT_POS2L: cur_byte = head_cmd.pos_code[7:0];
         ssw_pkg::SLOT_POS2H: cur_byte = {6'd0, head_cmd.pos_code[9:8]};
         ssw_pkg::SLOT_SPD2L: cur_byte = head_cmd.spd_code[7:0];
         ssw_pkg::SLOT_SPD2H: cur_byte = {6'd0, head_cmd.spd_code[9:8]};
         ssw_pkg::SLOT_CHK:   cur_byte = ~sum_ff;
         default:             cur_byte = 8'd0;
      endcase
   end

   always_comb begin
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         slot_in      = (slot_ff == ssw_pkg::SLOT_CHK) ? ssw_pkg::SLOT_HDR0 : slot_ff + 5'd1;
         // checksum covers broadcast ID through last speed byte
         sum_in       = (slot_ff < ssw_pkg::SLOT_BCAST) ? 8'd0 : sum_ff + cur_byte;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= ssw_pkg::SLOT_HDR0;
         sum_ff       <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= cur_byte;
         out_last_ff <= (slot_ff == ssw_pkg::SLOT_CHK);
      end
   end

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= ssw_pkg::SLOT_CHK)
      else $error("packet slot out of range");

   a_pop_wraps: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (slot_ff == ssw_pkg::SLOT_HDR0) && out_last_ff && out_valid_ff)
      else $error("command retired without checksum word");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |=> $stable(slot_ff) && $stable(out_byte_ff))
      else $error("sequencer moved while result stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/servo_sync_write_framer_unit.sv
// Top level of the servo sync-write framer: register file, front end, command
// queue and packet sequencer. Depends on ssw_pkg, ssw_front, ssw_queue, ssw_back.
`default_nettype none

// Each command (angle in degrees, speed in rpm) becomes one 18-word broadcast
// sync-write packet, one byte per word, low byte first for each 10-bit code,
// last_byte set on the closing checksum word. The angle maps to 1024*a/300 and
// the speed to 1024*s/114, truncated, both saturating at 1023. The sequencer
// emits one word per cycle while pops keep up, so the result port sets the
// sustained command rate. The front end scales a command in its accept cycle
// and parks it in a two-entry queue. The command being framed keeps its queue
// entry until its checksum word is loaded, so one further command is taken
// while a packet is streaming out, and a second once the checksum word is
// loaded.
// Registers sit at byte addresses 0 (first servo ID),
// 4 (first servo position) and 8 (second servo ID); write them only while idle.
module servo_sync_write_framer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // command queue side
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [8:0]  req_angle_deg,
   input  wire logic [6:0]  req_speed_rpm,
   // packet word side
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last_byte,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   ssw_pkg::cfg_type cfg_ff, cfg_in;
   ssw_pkg::cmd_type front_cmd;
   ssw_pkg::cmd_type head_cmd;
   logic             head_valid;
   logic             head_pop;
   logic             csr_wr;
   logic [1:0]       csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // register writes; index 3 is unmapped and dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            ssw_pkg::REG_FIRST_ID:  cfg_in.first_id  = csr_pwdata[7:0];
            ssw_pkg::REG_FIRST_POS: cfg_in.first_pos = csr_pwdata[9:0];
            ssw_pkg::REG_SECOND_ID: cfg_in.second_id = csr_pwdata[7:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ssw_pkg::REG_FIRST_ID:  csr_prdata = {24'd0, cfg_ff.first_id};
         ssw_pkg::REG_FIRST_POS: csr_prdata = {22'd0, cfg_ff.first_pos};
         ssw_pkg::REG_SECOND_ID: csr_prdata = {24'd0, cfg_ff.second_id};
         default:                csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_id  <= 8'd1;
         cfg_ff.first_pos <= 10'd511;
         cfg_ff.second_id <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // scale in the accept cycle
   ssw_front u_front (
      .angle_deg (req_angle_deg),
      .speed_rpm (req_speed_rpm),
      .cmd       (front_cmd)
   );

   ssw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_cmd   (front_cmd),
      .full       (req_full),
      .pop        (head_pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid)
   );

   ssw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop),
      .tx_byte    (rsp_tx_byte),
      .last_byte  (rsp_last_byte),
      .empty      (rsp_empty),
      .pop        (rsp_pop)
   );

   a_last_means_retire: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("queue retired with no command");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_full && !head_pop) |=> req_full)
      else $error("queue full cleared without retire");

   a_cfg_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_wr |=> $stable(cfg_ff))
      else $error("register changed without write");

endmodule

`default_nettype wire
